@@ src/tpba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpba_pkg
// Command and result types and code points of the tagged page-pool allocator.
// ----------------------------------------------------------------------------
package tpba_pkg;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_CREATE = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_NO_PAGE   = 3'd2;
	localparam logic [2:0] ST_NO_OWNER  = 3'd3;
	localparam logic [2:0] ST_INACTIVE  = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  owner;
		logic [21:0] request_bytes;
		logic [63:0] category;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  page_index;
		logic [20:0] page_offset;
		logic [6:0]  new_owner;
		logic [8:0]  pages_in_use;
		logic [8:0]  pages_backed;
	} rsp_t;

endpackage
`default_nettype wire

@@ src/tagged_pool_bump_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_pool_bump_allocator_top
// Page-pool bump allocator with owner slots and category-tagged pages.
// ----------------------------------------------------------------------------
// Usage: drive item and raise start; the command is taken at a clock edge
// with start high and busy low. busy stays high until the command finishes.
// The result appears on result for exactly one cycle with done high; the
// receiver cannot stall it, and the next command may be started in that
// same cycle.
// Sequence: an unused command, an inactive owner or a too-large request
// finishes from idle; an allocate reads the owner's current page and, if
// the request does not fit, scans from page 0 for the first free page and
// then orphans a current page; clear scans every page; create scans owner
// slots from 1 up. The page scans read each table entry through the
// registered read port of the page tables; create scans one slot a cycle.
// Reset clears the owner-active and page-claimed flags and the counters at
// once; unclaimed pages read as free, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_pool_bump_allocator_top #(
	parameter int NUM_PAGES  = 256,
	parameter int NUM_OWNERS = 128,
	parameter int PAGE_BYTES = 2097152,
	parameter int ALIGN_PAD  = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire tpba_pkg::cmd_t item,
	output logic                done,
	output tpba_pkg::rsp_t      result
);

	localparam int PW  = $clog2(NUM_PAGES);
	localparam int OW  = $clog2(NUM_OWNERS);
	localparam int HW  = $clog2(NUM_OWNERS + 1);
	localparam int OPW = $clog2(NUM_PAGES + 1);
	localparam int BW  = $clog2(PAGE_BYTES + 1);
	localparam int NW  = ((BW > 22) ? BW : 22) + 1;
	localparam int OCW = ((OW > 7) ? OW : 7) + 1;
	localparam int CW  = $clog2(NUM_PAGES + 1);

	localparam logic [HW-1:0]  HOLD_FREE   = '0;
	localparam logic [HW-1:0]  HOLD_ORPHAN = HW'(NUM_OWNERS);
	localparam logic [OPW-1:0] PAGE_NONE   = OPW'(NUM_PAGES);

	typedef enum logic [3:0] {
		S_IDLE, S_A_OWN, S_A_PAGE, S_A_LEFT, S_A_FIT,
		S_F_RD, S_F_CHK, S_A_ORPH, S_C_RD, S_C_CHK, S_CR
	} state_t;

	state_t state_q;

	// tables
	logic [HW-1:0]  holder_mem [NUM_PAGES];
	logic [BW-1:0]  left_mem   [NUM_PAGES];
	logic [63:0]    tag_mem    [NUM_PAGES];
	logic [OPW-1:0] opage_mem  [NUM_OWNERS];

	logic [HW-1:0]  holder_rd_q;
	logic [BW-1:0]  left_rd_q;
	logic [63:0]    tag_rd_q;
	logic [OPW-1:0] opage_rd_q;

	logic [NUM_PAGES-1:0]  page_valid_q;   // page ever claimed
	logic [NUM_OWNERS-1:0] owner_active_q;
	logic [CW-1:0]         in_use_q;
	logic [CW-1:0]         backed_q;

	// command context
	logic [OW-1:0]  own_q;
	logic [NW-1:0]  need_q;
	logic [63:0]    cat_q;
	logic [OPW-1:0] cur_q;
	logic [PW-1:0]  pa_q;
	logic [OW-1:0]  oc_q;

	// registered write requests
	logic           hw_en_q, lw_en_q, tw_en_q, ow_en_q;
	logic [PW-1:0]  hw_addr_q, lw_addr_q, tw_addr_q;
	logic [OW-1:0]  ow_addr_q;
	logic [HW-1:0]  hw_data_q;
	logic [BW-1:0]  lw_data_q;
	logic [63:0]    tw_data_q;
	logic [OPW-1:0] ow_data_q;

	// result
	logic           done_q;
	logic [2:0]     status_q;
	logic [7:0]     pidx_q;
	logic [20:0]    poff_q;
	logic [6:0]     nown_q;

	logic [OCW-1:0] owner_x;
	logic           owner_ok;
	logic [NW-1:0]  need_in;
	logic           cur_fits;
	logic           page_free;

	always_comb begin
		owner_x  = OCW'(item.owner);
		owner_ok = (owner_x != '0) && (owner_x < OCW'(NUM_OWNERS))
			&& owner_active_q[owner_x[OW-1:0]];
		need_in  = NW'(item.request_bytes) + NW'(ALIGN_PAD);
		cur_fits = (cur_q < PAGE_NONE) && page_valid_q[cur_q[PW-1:0]]
			&& (NW'(left_rd_q) >= need_q);
		page_free = !page_valid_q[pa_q] || (holder_rd_q == HOLD_FREE);
	end

	always_ff @(posedge clk) begin
		holder_rd_q <= holder_mem[pa_q];
		left_rd_q   <= left_mem[pa_q];
		tag_rd_q    <= tag_mem[pa_q];
		opage_rd_q  <= opage_mem[own_q];
		if (hw_en_q) holder_mem[hw_addr_q] <= hw_data_q;
		if (lw_en_q) left_mem[lw_addr_q] <= lw_data_q;
		if (tw_en_q) tag_mem[tw_addr_q] <= tw_data_q;
		if (ow_en_q) opage_mem[ow_addr_q] <= ow_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			page_valid_q   <= '0;
			owner_active_q <= '0;
			in_use_q       <= '0;
			backed_q       <= '0;
			own_q          <= '0;
			need_q         <= '0;
			cat_q          <= '0;
			cur_q          <= '0;
			pa_q           <= '0;
			oc_q           <= '0;
			hw_en_q        <= 1'b0;
			lw_en_q        <= 1'b0;
			tw_en_q        <= 1'b0;
			ow_en_q        <= 1'b0;
			hw_addr_q      <= '0;
			lw_addr_q      <= '0;
			tw_addr_q      <= '0;
			ow_addr_q      <= '0;
			hw_data_q      <= '0;
			lw_data_q      <= '0;
			tw_data_q      <= '0;
			ow_data_q      <= '0;
			done_q         <= 1'b0;
			status_q       <= '0;
			pidx_q         <= '0;
			poff_q         <= '0;
			nown_q         <= '0;
		end else begin
			done_q  <= 1'b0;
			hw_en_q <= 1'b0;
			lw_en_q <= 1'b0;
			tw_en_q <= 1'b0;
			ow_en_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						own_q    <= owner_x[OW-1:0];
						need_q   <= need_in;
						cat_q    <= item.category;
						status_q <= tpba_pkg::ST_OK;
						pidx_q   <= '0;
						poff_q   <= '0;
						nown_q   <= '0;
						pa_q     <= '0;
						oc_q     <= OW'(1);
						unique case (item.command)
							tpba_pkg::CMD_ALLOC: begin
								if (!owner_ok) begin
									status_q <= tpba_pkg::ST_INACTIVE;
									state_q  <= S_IDLE;
									done_q   <= 1'b1;
								end else if (need_in > NW'(PAGE_BYTES)) begin
									status_q <= tpba_pkg::ST_TOO_LARGE;
									state_q  <= S_IDLE;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_A_OWN;
								end
							end
							tpba_pkg::CMD_CLEAR:  state_q <= S_C_RD;
							tpba_pkg::CMD_CREATE: state_q <= S_CR;
							default: begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						endcase
					end
				end
				S_A_OWN: state_q <= S_A_PAGE;
				S_A_PAGE: begin
					cur_q   <= opage_rd_q;
					pa_q    <= opage_rd_q[PW-1:0];
					state_q <= S_A_LEFT;
				end
				S_A_LEFT: state_q <= S_A_FIT;
				S_A_FIT: begin
					if (cur_fits) begin
						lw_en_q   <= 1'b1;
						lw_addr_q <= cur_q[PW-1:0];
						lw_data_q <= BW'(NW'(left_rd_q) - need_q);
						pidx_q    <= 8'(cur_q);
						poff_q    <= 21'(BW'(PAGE_BYTES) - left_rd_q);
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
					end else begin
						pa_q    <= '0;
						state_q <= S_F_RD;
					end
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (page_free) begin
						hw_en_q   <= 1'b1;
						hw_addr_q <= pa_q;
						hw_data_q <= HW'(own_q);
						lw_en_q   <= 1'b1;
						lw_addr_q <= pa_q;
						lw_data_q <= BW'(NW'(PAGE_BYTES) - need_q);
						tw_en_q   <= 1'b1;
						tw_addr_q <= pa_q;
						tw_data_q <= cat_q;
						ow_en_q   <= 1'b1;
						ow_addr_q <= own_q;
						ow_data_q <= OPW'(pa_q);
						page_valid_q[pa_q] <= 1'b1;
						if (!page_valid_q[pa_q]) backed_q <= backed_q + CW'(1);
						in_use_q <= in_use_q + CW'(1);
						pidx_q   <= 8'(pa_q);
						poff_q   <= '0;
						if (cur_q < PAGE_NONE) begin
							state_q <= S_A_ORPH;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end else if (pa_q == PW'(NUM_PAGES - 1)) begin
						status_q <= tpba_pkg::ST_NO_PAGE;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else begin
						pa_q    <= pa_q + PW'(1);
						state_q <= S_F_RD;
					end
				end
				S_A_ORPH: begin
					hw_en_q   <= 1'b1;
					hw_addr_q <= cur_q[PW-1:0];
					hw_data_q <= HOLD_ORPHAN;
					state_q   <= S_IDLE;
					done_q    <= 1'b1;
				end
				S_C_RD: state_q <= S_C_CHK;
				S_C_CHK: begin
					// never-claimed pages stay free and are refilled on claim
					if (page_valid_q[pa_q] && (tag_rd_q == cat_q)) begin
						lw_en_q   <= 1'b1;
						lw_addr_q <= pa_q;
						lw_data_q <= BW'(PAGE_BYTES);
						if (holder_rd_q == HOLD_ORPHAN) begin
							hw_en_q   <= 1'b1;
							hw_addr_q <= pa_q;
							hw_data_q <= HOLD_FREE;
							in_use_q  <= in_use_q - CW'(1);
						end
					end
					if (pa_q == PW'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						pa_q    <= pa_q + PW'(1);
						state_q <= S_C_RD;
					end
				end
				S_CR: begin
					if (!owner_active_q[oc_q]) begin
						owner_active_q[oc_q] <= 1'b1;
						ow_en_q   <= 1'b1;
						ow_addr_q <= oc_q;
						ow_data_q <= PAGE_NONE;
						nown_q    <= 7'(oc_q);
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
					end else if (oc_q == OW'(NUM_OWNERS - 1)) begin
						status_q <= tpba_pkg::ST_NO_OWNER;
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
					end else begin
						oc_q <= oc_q + OW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		result.status       = status_q;
		result.page_index   = pidx_q;
		result.page_offset  = poff_q;
		result.new_owner    = nown_q;
		result.pages_in_use = 9'(in_use_q);
		result.pages_backed = 9'(backed_q);
	end

endmodule
`default_nettype wire

@@ src/tpba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tpba_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire tpba_pkg::rsp_t result
);

	// an accepted command either finishes at once or holds busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != tpba_pkg::ST_OK)) |->
		((result.page_index == '0) && (result.page_offset == '0)
		&& (result.new_owner == '0)))
		else $error("error result carries page or owner fields");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.pages_in_use <= result.pages_backed))
		else $error("more pages in use than backed");

endmodule

bind tagged_pool_bump_allocator_top tpba_checker u_tpba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
